FILE: hdl/meter_frame_finder_assert.svh
// meter_frame_finder_assert.svh: assertion macros shared by the frame finder rtl
// expects clk and arst_n in the scope where the macros are used
`ifndef METER_FRAME_FINDER_ASSERT_SVH
`define METER_FRAME_FINDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MFF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MFF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/mff_pkg.sv
// mff_pkg: constants and command codes of the meter frame finder
// no dependencies
package mff_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	// widest position probed: offset + length byte + trailer distance
	localparam int POS_W = $clog2(BUFFER_DEPTH + 256 + 16);
	// checksum span is length + 10, at most 265
	localparam int SPAN_W = 9;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_SCAN   = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	localparam logic KIND_SCAN = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [7:0] HEAD_MARK = 8'h68;
	localparam logic [7:0] TAIL_MARK = 8'h16;
	localparam logic [7:0] BYTE_BIAS = 8'h33;
	localparam logic [7:0] EXCL_BROADCAST = 8'hE5;
	// identifier patterns as {id3, id2, id1, id0}
	localparam logic [31:0] EXCL_ID_A = 32'h0400_010C;
	localparam logic [31:0] EXCL_ID_B = 32'h04A0_0600;

	localparam int HEAD2_OFS = 7;
	localparam int LEN_OFS = 9;
	localparam int DATA_OFS = 10;
	localparam int CSUM_OFS = 10;
	localparam int TAIL_OFS = 11;
	localparam int FRAME_EXTRA = 12;
	localparam int ID_BYTES = 4;

endpackage

FILE: hdl/meter_frame_finder.sv
// meter_frame_finder: byte buffer with a serial frame scanner
// depends on mff_pkg and meter_frame_finder_assert.svh
//
// Bytes are appended to a synchronous buffer of BUFFER_DEPTH entries with one write port and
// one registered read port; a clear or an append completes when accepted and gives no result.
// A payload read holds off the input through its read-wait and result states. A scan, once
// accepted, walks start offsets through the read port, one byte per cycle: an offset is left
// when its first byte is not a start mark, when its second or tail mark fails, when the checksum
// over its L + 10 bytes fails or when its identifier is excluded, L being its length byte; a
// result state then loads the result. Results sit in an output register, so appends keep
// flowing while one waits; a second scan or read stalls in its result state until the held
// result is taken.
module meter_frame_finder (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_index,
	output logic out_valid,
	input  logic out_ready,
	output logic result_kind,
	output logic frame_found,
	output logic [7:0] payload_length,
	output logic [7:0] payload_byte
);
	import mff_pkg::*;

	`include "meter_frame_finder_assert.svh"

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RDW   = 4'd1;
	localparam logic [3:0] ST_CAND  = 4'd2;
	localparam logic [3:0] ST_HEAD0 = 4'd3;
	localparam logic [3:0] ST_HEAD7 = 4'd4;
	localparam logic [3:0] ST_LEN   = 4'd5;
	localparam logic [3:0] ST_TAIL  = 4'd6;
	localparam logic [3:0] ST_CKB   = 4'd7;
	localparam logic [3:0] ST_SUM   = 4'd8;
	localparam logic [3:0] ST_EXC   = 4'd9;
	localparam logic [3:0] ST_RES   = 4'd10;

	logic [7:0] byte_store_q [BUFFER_DEPTH];
	logic [7:0] rdata_s1;
	logic rin_s1;
	logic pend_s1;

	logic [3:0] state_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [ADDR_W-1:0] frame_offset_q;
	logic [7:0] found_len_q;
	logic have_frame_q;

	logic [ADDR_W-1:0] ofs_q;
	logic [7:0] len_q;
	logic [7:0] ck_q;
	logic [7:0] acc_q;
	logic [SPAN_W-1:0] k_q;
	logic [31:0] id_q;
	logic rd_ok_q;
	logic kind_q;
	logic [7:0] pbyte_q;

	logic out_valid_q;
	logic result_kind_q;
	logic frame_found_q;
	logic [7:0] payload_length_q;
	logic [7:0] payload_byte_q;

	logic in_fire;
	logic wr_en;
	logic [7:0] rbyte;
	logic [POS_W-1:0] rd_pos;
	logic [POS_W-1:0] ofs_ext;
	logic [POS_W-1:0] cnt_ext;
	logic [POS_W-1:0] frame_end;
	logic [SPAN_W-1:0] sum_n;
	logic sum_issue;
	logic id_issue;
	logic id_excluded;
	logic out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign wr_en = in_fire && (cmd == CMD_APPEND) && (byte_count_q < CNT_W'(BUFFER_DEPTH));
	// positions at or past the fill count read as zero
	assign rbyte = rin_s1 ? rdata_s1 : 8'd0;
	assign ofs_ext = POS_W'(ofs_q);
	assign cnt_ext = POS_W'(byte_count_q);
	assign frame_end = ofs_ext + POS_W'(rbyte) + POS_W'(FRAME_EXTRA);
	assign sum_n = SPAN_W'(len_q) + SPAN_W'(CSUM_OFS);
	assign sum_issue = (k_q < sum_n);
	assign id_issue = (k_q < SPAN_W'(ID_BYTES));
	assign out_free = !out_valid_q || out_ready;

	assign id_excluded = ((id_q[23:16] == EXCL_BROADCAST) && (id_q[31:24] == EXCL_BROADCAST))
		|| (id_q == EXCL_ID_A) || (id_q == EXCL_ID_B);

	always_comb begin
		case (state_q)
			ST_IDLE:  rd_pos = POS_W'(frame_offset_q) + POS_W'(DATA_OFS) + POS_W'(read_index);
			ST_CAND:  rd_pos = ofs_ext;
			ST_HEAD0: rd_pos = ofs_ext + POS_W'(HEAD2_OFS);
			ST_HEAD7: rd_pos = ofs_ext + POS_W'(LEN_OFS);
			ST_LEN:   rd_pos = ofs_ext + POS_W'(rbyte) + POS_W'(TAIL_OFS);
			ST_TAIL:  rd_pos = ofs_ext + POS_W'(len_q) + POS_W'(CSUM_OFS);
			ST_SUM:   rd_pos = ofs_ext + POS_W'(k_q);
			ST_EXC:   rd_pos = ofs_ext + POS_W'(DATA_OFS) + POS_W'(k_q);
			default:  rd_pos = ofs_ext;
		endcase
	end

	// buffer: one write port for appends, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			byte_store_q[byte_count_q[ADDR_W-1:0]] <= rx_byte;
		end
		rdata_s1 <= byte_store_q[rd_pos[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			byte_count_q <= '0;
			frame_offset_q <= '0;
			found_len_q <= '0;
			have_frame_q <= 1'b0;
			rin_s1 <= 1'b0;
			pend_s1 <= 1'b0;
			ofs_q <= '0;
			len_q <= '0;
			ck_q <= '0;
			acc_q <= '0;
			k_q <= '0;
			id_q <= '0;
			rd_ok_q <= 1'b0;
			kind_q <= KIND_SCAN;
			pbyte_q <= '0;
			out_valid_q <= 1'b0;
			result_kind_q <= KIND_SCAN;
			frame_found_q <= 1'b0;
			payload_length_q <= '0;
			payload_byte_q <= '0;
		end else begin
			rin_s1 <= (rd_pos < cnt_ext);
			pend_s1 <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (cmd)
							CMD_CLEAR: begin
								byte_count_q <= '0;
								frame_offset_q <= '0;
								found_len_q <= '0;
								have_frame_q <= 1'b0;
							end
							CMD_APPEND: begin
								if (wr_en) begin
									byte_count_q <= byte_count_q + 1'b1;
								end
							end
							CMD_SCAN: begin
								kind_q <= KIND_SCAN;
								ofs_q <= '0;
								state_q <= ST_CAND;
							end
							default: begin
								kind_q <= KIND_READ;
								rd_ok_q <= have_frame_q && (read_index < found_len_q);
								state_q <= ST_RDW;
							end
						endcase
					end
				end
				ST_RDW: begin
					pbyte_q <= rd_ok_q ? (rbyte - BYTE_BIAS) : 8'd0;
					state_q <= ST_RES;
				end
				ST_CAND: begin
					// no room left for a header: the scan ends empty-handed
					if (ofs_ext + POS_W'(HEAD2_OFS) >= cnt_ext) begin
						have_frame_q <= 1'b0;
						frame_offset_q <= '0;
						found_len_q <= '0;
						pbyte_q <= '0;
						state_q <= ST_RES;
					end else begin
						state_q <= ST_HEAD0;
					end
				end
				ST_HEAD0: begin
					if (rbyte == HEAD_MARK) begin
						state_q <= ST_HEAD7;
					end else begin
						ofs_q <= ofs_q + 1'b1;
						state_q <= ST_CAND;
					end
				end
				ST_HEAD7: begin
					if (rbyte == HEAD_MARK) begin
						state_q <= ST_LEN;
					end else begin
						ofs_q <= ofs_q + 1'b1;
						state_q <= ST_CAND;
					end
				end
				ST_LEN: begin
					len_q <= rbyte;
					if (frame_end > cnt_ext) begin
						have_frame_q <= 1'b0;
						frame_offset_q <= '0;
						found_len_q <= '0;
						pbyte_q <= '0;
						state_q <= ST_RES;
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (rbyte == TAIL_MARK) begin
						state_q <= ST_CKB;
					end else begin
						ofs_q <= ofs_q + 1'b1;
						state_q <= ST_CAND;
					end
				end
				ST_CKB: begin
					ck_q <= rbyte;
					acc_q <= '0;
					k_q <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// one address issued and one byte summed per cycle
					pend_s1 <= sum_issue;
					if (sum_issue) begin
						k_q <= k_q + 1'b1;
					end
					if (pend_s1) begin
						acc_q <= acc_q + rbyte;
					end
					if (!sum_issue && !pend_s1) begin
						if (acc_q == ck_q) begin
							k_q <= '0;
							state_q <= ST_EXC;
						end else begin
							ofs_q <= ofs_q + 1'b1;
							state_q <= ST_CAND;
						end
					end
				end
				ST_EXC: begin
					pend_s1 <= id_issue;
					if (id_issue) begin
						k_q <= k_q + 1'b1;
					end
					if (pend_s1) begin
						id_q <= {rbyte - BYTE_BIAS, id_q[31:8]};
					end
					if (!id_issue && !pend_s1) begin
						if (id_excluded) begin
							ofs_q <= ofs_q + 1'b1;
							state_q <= ST_CAND;
						end else begin
							have_frame_q <= 1'b1;
							frame_offset_q <= ofs_q;
							found_len_q <= len_q;
							pbyte_q <= '0;
							state_q <= ST_RES;
						end
					end
				end
				ST_RES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						result_kind_q <= kind_q;
						frame_found_q <= have_frame_q;
						payload_length_q <= found_len_q;
						payload_byte_q <= pbyte_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = result_kind_q;
	assign frame_found = frame_found_q;
	assign payload_length = payload_length_q;
	assign payload_byte = payload_byte_q;

	`MFF_ASSERT_NOW(a_count_bound, 1'b1, byte_count_q <= CNT_W'(BUFFER_DEPTH), "fill count past buffer depth")
	`MFF_ASSERT_NOW(a_frame_inside, have_frame_q, POS_W'(frame_offset_q) + POS_W'(found_len_q) + POS_W'(FRAME_EXTRA) <= cnt_ext, "kept frame runs past buffered bytes")
	`MFF_ASSERT_NOW(a_no_frame_len, out_valid && !frame_found, payload_length == 8'd0, "length reported without a frame")
	`MFF_ASSERT_NOW(a_scan_byte_zero, out_valid && (result_kind == KIND_SCAN), payload_byte == 8'd0, "scan result carries a payload byte")
	`MFF_ASSERT_NEXT(a_scan_busy, in_fire && (cmd == CMD_SCAN), !in_ready, "scan transaction did not start the walk")

endmodule

FILE: dv/mff_tb_pkg.sv
`timescale 1ns / 100ps
// mff_tb_pkg: result prediction and scoreboard for the meter frame finder testbench
// depends on mff_pkg for command codes, frame marks and buffer depth
package mff_tb_pkg;
	import mff_pkg::*;

	typedef struct packed {
		logic       kind;
		logic       found;
		logic [7:0] plen;
		logic [7:0] pbyte;
	} frame_result_t;

	class frame_scoreboard;
		logic [7:0] store [BUFFER_DEPTH];
		int unsigned fill = 0;
		int unsigned frame_base = 0;
		int unsigned frame_len = 0;
		bit have_frame = 0;
		frame_result_t awaited [$];
		int errors = 0;
		int scans = 0;
		int hits = 0;
		int reads = 0;
		int dropped = 0;

		// anything at or past the fill level reads as zero
		function logic [7:0] byte_at(int unsigned pos);
			if (pos >= fill)
				return 8'h00;
			return store[pos];
		endfunction

		function logic [7:0] unbiased(int unsigned pos);
			return byte_at(pos) - BYTE_BIAS;
		endfunction

		function bit id_excluded(int unsigned base);
			logic [31:0] id;
			id = {unbiased(base + DATA_OFS + 3), unbiased(base + DATA_OFS + 2),
				unbiased(base + DATA_OFS + 1), unbiased(base + DATA_OFS)};
			if (id[31:24] == EXCL_BROADCAST && id[23:16] == EXCL_BROADCAST)
				return 1'b1;
			return id == EXCL_ID_A || id == EXCL_ID_B;
		endfunction

		// first passing candidate wins; a candidate running past the fill level ends the search
		function bit find_frame();
			int unsigned len;
			logic [7:0] sum;
			for (int unsigned i = 0; i < fill; i++) begin
				if (i + HEAD2_OFS >= fill)
					return 1'b0;
				if (byte_at(i) != HEAD_MARK || byte_at(i + HEAD2_OFS) != HEAD_MARK)
					continue;
				len = byte_at(i + LEN_OFS);
				if (i + len + FRAME_EXTRA > fill)
					return 1'b0;
				if (byte_at(i + len + TAIL_OFS) != TAIL_MARK)
					continue;
				sum = 8'h00;
				for (int unsigned k = 0; k < len + CSUM_OFS; k++)
					sum += byte_at(i + k);
				if (sum != byte_at(i + len + CSUM_OFS))
					continue;
				if (id_excluded(i))
					continue;
				frame_base = i;
				frame_len = len;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_input(logic [1:0] op, logic [7:0] rx, logic [7:0] idx);
			frame_result_t r;
			case (op)
			CMD_CLEAR: begin
				fill = 0;
				frame_base = 0;
				frame_len = 0;
				have_frame = 1'b0;
			end
			CMD_APPEND: begin
				if (fill < BUFFER_DEPTH) begin
					store[fill] = rx;
					fill++;
				end else begin
					dropped++;
				end
			end
			CMD_SCAN: begin
				have_frame = find_frame();
				if (!have_frame) begin
					frame_base = 0;
					frame_len = 0;
				end
				scans++;
				if (have_frame)
					hits++;
				r.kind = KIND_SCAN;
				r.found = have_frame;
				r.plen = frame_len[7:0];
				r.pbyte = 8'h00;
				awaited.push_back(r);
			end
			default: begin
				// payload read
				reads++;
				r.kind = KIND_READ;
				r.found = have_frame;
				r.plen = frame_len[7:0];
				if (have_frame && idx < frame_len)
					r.pbyte = unbiased(frame_base + DATA_OFS + idx);
				else
					r.pbyte = 8'h00;
				awaited.push_back(r);
			end
			endcase
		endfunction

		function void mismatch(string field, int unsigned want, int unsigned got);
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got kind %0h found %0h len %0h byte %0h",
					$time, got.kind, got.found, got.plen, got.pbyte);
				return;
			end
			want = awaited.pop_front();
			if (got.kind !== want.kind)
				mismatch("result_kind", want.kind, got.kind);
			if (got.found !== want.found)
				mismatch("frame_found", want.found, got.found);
			if (got.plen !== want.plen)
				mismatch("payload_length", want.plen, got.plen);
			if (got.pbyte !== want.pbyte)
				mismatch("payload_byte", want.pbyte, got.pbyte);
		endfunction

		function void check_leftover();
			if (awaited.size() != 0) begin
				errors++;
				$display("%0t: %0d results never arrived", $time, awaited.size());
			end
		endfunction
	endclass

endpackage

FILE: dv/tb_meter_frame_finder.sv
`timescale 1ns / 100ps
// tb_meter_frame_finder: drives clears, byte appends, scans and payload reads into the frame finder
// depends on mff_pkg, mff_tb_pkg and the meter_frame_finder rtl
module tb_meter_frame_finder;
	import mff_pkg::*;
	import mff_tb_pkg::*;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int PHASE_ITEMS = 420;

	typedef enum {FLAW_NONE, FLAW_HEAD, FLAW_SUM, FLAW_TAIL, FLAW_CUT} frame_flaw_t;
	typedef enum {ID_RANDOM, ID_BCAST, ID_PATTERN_A, ID_PATTERN_B, ID_NEAR_MISS} ident_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_CLEAR;
	logic [7:0] rx_byte = 8'h00;
	logic [7:0] read_index = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic frame_found;
	logic [7:0] payload_length;
	logic [7:0] payload_byte;

	frame_scoreboard sb = new;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int stall_request = 0;
	int stall_left = 0;
	int items_done = 0;

	meter_frame_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.rx_byte(rx_byte),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.frame_found(frame_found),
		.payload_length(payload_length),
		.payload_byte(payload_byte)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (stall_request != 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left != 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(frame_result_t'({result_kind, frame_found, payload_length,
				payload_byte}));
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES,
			sb.awaited.size());
		$display("FAIL");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send(input logic [1:0] op, input logic [7:0] rx, input logic [7:0] idx);
		bit counts;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd = op;
		rx_byte = rx;
		read_index = idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// an append into a full buffer does nothing and is not counted
		counts = !(op == CMD_APPEND && sb.fill >= BUFFER_DEPTH);
		sb.note_input(op, rx, idx);
		if (counts)
			items_done++;
		@(negedge clk);
	endtask

	task automatic send_bytes(input logic [7:0] q [$]);
		foreach (q[k])
			send(CMD_APPEND, q[k], 8'($urandom));
	endtask

	task automatic send_read();
		logic [7:0] idx;
		if (sb.have_frame && sb.frame_len > 0 && $urandom_range(99) < 70)
			idx = 8'($urandom_range(sb.frame_len - 1));
		else if ($urandom_range(1) == 0)
			idx = sb.frame_len[7:0];
		else
			idx = 8'($urandom);
		send(CMD_READ, 8'($urandom), idx);
	endtask

	function automatic frame_flaw_t pick_flaw();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return FLAW_NONE;
		if (r < 65)
			return FLAW_HEAD;
		if (r < 78)
			return FLAW_SUM;
		if (r < 90)
			return FLAW_TAIL;
		return FLAW_CUT;
	endfunction

	function automatic ident_kind_t pick_ident();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return ID_RANDOM;
		if (r < 70)
			return ID_BCAST;
		if (r < 80)
			return ID_PATTERN_A;
		if (r < 90)
			return ID_PATTERN_B;
		return ID_NEAR_MISS;
	endfunction

	function automatic int unsigned pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(12);
		if (r < 97)
			return $urandom_range(13, 60);
		return $urandom_range(61, 200);
	endfunction

	function automatic void build_frame(ref logic [7:0] q [$], input int unsigned len,
			input frame_flaw_t flaw, input ident_kind_t ident);
		logic [7:0] f [$];
		logic [7:0] sum;
		logic [31:0] id;
		f.push_back(HEAD_MARK);
		repeat (6)
			f.push_back(8'($urandom));
		f.push_back(flaw == FLAW_HEAD ? HEAD_MARK ^ 8'($urandom_range(1, 255)) : HEAD_MARK);
		f.push_back(8'($urandom));
		f.push_back(len[7:0]);
		case (ident)
		ID_BCAST: id = {EXCL_BROADCAST, EXCL_BROADCAST, 16'($urandom)};
		ID_PATTERN_A: id = EXCL_ID_A;
		ID_PATTERN_B: id = EXCL_ID_B;
		ID_NEAR_MISS: id = EXCL_ID_A ^ (32'd1 << $urandom_range(31));
		default: id = $urandom;
		endcase
		// identifier sits at the head of the data field, low byte first, biased on the wire
		for (int unsigned k = 0; k < len; k++)
			f.push_back(k < ID_BYTES ? id[8 * k +: 8] + BYTE_BIAS : 8'($urandom));
		sum = 8'h00;
		foreach (f[k])
			sum += f[k];
		f.push_back(flaw == FLAW_SUM ? sum + 8'($urandom_range(1, 255)) : sum);
		f.push_back(flaw == FLAW_TAIL ? TAIL_MARK ^ 8'($urandom_range(1, 255)) : TAIL_MARK);
		if (flaw == FLAW_CUT)
			repeat ($urandom_range(1, 3))
				void'(f.pop_back());
		foreach (f[k])
			q.push_back(f[k]);
	endfunction

	task automatic run_scenario(input bit big);
		logic [7:0] q [$];
		if (big || $urandom_range(99) < 70)
			send(CMD_CLEAR, 8'($urandom), 8'($urandom));
		if (big) begin
			if ($urandom_range(1) == 0) begin
				// a frame that fills the whole buffer
				build_frame(q, BUFFER_DEPTH - FRAME_EXTRA,
					$urandom_range(1) ? FLAW_NONE : pick_flaw(), ID_RANDOM);
			end else begin
				repeat (200)
					q.push_back(8'($urandom));
				build_frame(q, $urandom_range(40), FLAW_NONE, pick_ident());
			end
			repeat ($urandom_range(3, 6))
				q.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(6))
				q.push_back($urandom_range(3) == 0 ? HEAD_MARK : 8'($urandom));
			if ($urandom_range(99) < 8) begin
				// header whose length runs off the end stops the scan before a good frame
				q.push_back(HEAD_MARK);
				repeat (6)
					q.push_back(8'($urandom));
				q.push_back(HEAD_MARK);
				q.push_back(8'($urandom));
				q.push_back(8'($urandom_range(200, 255)));
			end
			repeat ($urandom_range(1, 3))
				build_frame(q, pick_len(), pick_flaw(), pick_ident());
		end
		send_bytes(q);
		send(CMD_SCAN, 8'($urandom), 8'($urandom));
		repeat ($urandom_range(1, 4))
			send_read();
		if ($urandom_range(99) < 20) begin
			q = {};
			build_frame(q, pick_len(), pick_flaw(), pick_ident());
			send_bytes(q);
			send(CMD_SCAN, 8'($urandom), 8'($urandom));
			send_read();
		end
		if ($urandom_range(99) < 10)
			repeat ($urandom_range(1, 5))
				send(2'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		logic [7:0] q [$];
		logic [7:0] sum;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty buffer, then a one-byte frame whose payload wraps to 0xff
		send(CMD_SCAN, 8'h00, 8'hFF);
		send(CMD_READ, 8'hFF, 8'h00);
		q = {HEAD_MARK, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, HEAD_MARK, 8'h91, 8'h01,
			8'h32};
		sum = 8'h00;
		foreach (q[k])
			sum += q[k];
		q.push_back(sum);
		q.push_back(TAIL_MARK);
		send_bytes(q);
		send(CMD_SCAN, 8'hFF, 8'h00);
		send(CMD_READ, 8'h00, 8'h00);
		send(CMD_READ, 8'h00, 8'h01);
		send(CMD_READ, 8'h00, 8'hFF);
		send(CMD_CLEAR, 8'hFF, 8'hFF);
		send(CMD_SCAN, 8'h00, 8'h00);
		send(CMD_READ, 8'hFF, 8'h00);

		for (int p = 0; p < 4; p++) begin
			int phase_end;
			case (p)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
			default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			phase_end = items_done + PHASE_ITEMS;
			if (p == 0) begin
				// long receiver hold-off while reads keep coming, so the input backs up
				run_scenario(1'b0);
				stall_request = 400;
				repeat (24)
					send_read();
			end
			if (p == 1)
				run_scenario(1'b1);
			while (items_done < phase_end)
				run_scenario($urandom_range(79) == 0);
		end

		in_valid = 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		sb.check_leftover();
		$display("ran %0d transactions: %0d scans with %0d frames found, %0d payload reads",
			items_done, sb.scans, sb.hits, sb.reads);
		$display("%0d appends dropped on a full buffer, %0d mismatches", sb.dropped, sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
